FILE: rtl/epc_pkg.sv
// ----------------------------------------------------------------------------
// Encoder position controller package
// Shared widths, codes, reset values and types for the controller blocks.
// ----------------------------------------------------------------------------
package epc_pkg;

    // Field widths
    localparam int FRAME_W  = 16;
    localparam int GOAL_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int ERR_W    = COUNT_W + 1;
    localparam int GAIN_W   = 16;
    localparam int DB_W     = 10;
    localparam int PW_W     = 12;
    localparam int DIR_W    = 2;
    localparam int SEL_W    = 2;
    localparam int PROD_W   = ERR_W + GAIN_W + 1;

    // Default parameter values
    localparam int ANGLE_BITS_DEF     = 10;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_DBAND  = 2'd1;
    localparam logic [1:0] REG_POSLIM = 2'd2;
    localparam logic [1:0] REG_NEGLIM = 2'd3;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd38;
    localparam logic [DB_W-1:0]   DBAND_RST  = 10'd100;
    localparam logic [PW_W-1:0]   POSLIM_RST = 12'd1350;
    localparam logic [PW_W-1:0]   NEGLIM_RST = 12'd1650;

    // Pulse width constants
    localparam logic [PW_W-1:0] STOP_PW   = 12'd1500;
    localparam logic [PW_W-1:0] POS_FLOOR = 12'd1350;
    localparam logic [PW_W-1:0] NEG_FLOOR = 12'd1650;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_NEG  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_POS  = 2'd2;

    // Drive select codes
    localparam logic [SEL_W-1:0] SEL_STOP = 2'd0;
    localparam logic [SEL_W-1:0] SEL_POS  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_NEG  = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_q8;
        logic [DB_W-1:0]   deadband_half;
        logic [PW_W-1:0]   pos_side_limit;
        logic [PW_W-1:0]   neg_side_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic [SEL_W-1:0]        sel;
        logic [COUNT_W-1:0]      count;
        logic [DIR_W-1:0]        dir;
    } t_err_item;

endpackage

FILE: rtl/epc_if.sv
// ----------------------------------------------------------------------------
// Encoder position controller stream interfaces
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface epc_in_if import epc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FRAME_W-1:0]       encoder_frame;
    logic signed [GOAL_W-1:0] target_count;
    logic                     limit_pressed;
    logic                     zero_count;

    modport source (
        output valid, encoder_frame, target_count, limit_pressed, zero_count,
        input  ready
    );
    modport sink (
        input  valid, encoder_frame, target_count, limit_pressed, zero_count,
        output ready
    );
endinterface

interface epc_out_if import epc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [PW_W-1:0]           drive_pw;
    logic signed [COUNT_W-1:0] position_count;
    logic [DIR_W-1:0]          direction;

    modport source (
        output valid, drive_pw, position_count, direction,
        input  ready
    );
    modport sink (
        input  valid, drive_pw, position_count, direction,
        output ready
    );
endinterface

FILE: rtl/epc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Encoder position controller configuration registers
// APB-style register file holding gain, deadband and clamp limits.
// ----------------------------------------------------------------------------
module epc_cfg_regs import epc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_q8        <= GAIN_RST;
            r_cfg.deadband_half  <= DBAND_RST;
            r_cfg.pos_side_limit <= POSLIM_RST;
            r_cfg.neg_side_limit <= NEGLIM_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GAIN:   r_cfg.gain_q8        <= pwdata[GAIN_W-1:0];
                REG_DBAND:  r_cfg.deadband_half  <= pwdata[DB_W-1:0];
                REG_POSLIM: r_cfg.pos_side_limit <= pwdata[PW_W-1:0];
                REG_NEGLIM: r_cfg.neg_side_limit <= pwdata[PW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back selected register
    always_comb begin
        case (reg_idx)
            REG_GAIN:   prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, r_cfg.gain_q8};
            REG_DBAND:  prdata = {{(CFG_DATA_W-DB_W){1'b0}}, r_cfg.deadband_half};
            REG_POSLIM: prdata = {{(CFG_DATA_W-PW_W){1'b0}}, r_cfg.pos_side_limit};
            REG_NEGLIM: prdata = {{(CFG_DATA_W-PW_W){1'b0}}, r_cfg.neg_side_limit};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/epc_track.sv
// ----------------------------------------------------------------------------
// Encoder position controller tracking stages
// Unwraps the angle into the position count, forms the error and updates
// the deadband direction state.
// ----------------------------------------------------------------------------
module epc_track import epc_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    epc_in_if.sink     i_in,
    output logic       o_valid,
    input  logic       i_ready,
    output t_err_item  o_item
);

    localparam int DW = ANGLE_BITS + 2;
    localparam logic signed [DW-1:0] HALF_S = DW'((2 ** (ANGLE_BITS - 1)) - 1);
    localparam logic signed [DW-1:0] FULL_S = DW'(2 ** ANGLE_BITS);

    // Stage 1: count update
    logic                     r1_valid;
    logic signed [GOAL_W-1:0] r1_goal;
    logic                     r1_lim;
    logic                     r1_zero;
    logic [ANGLE_BITS-1:0]    r_last_angle;
    logic [COUNT_W-1:0]       r_turn_count;

    // Stage 2: error and direction
    logic                     r2_valid;
    t_err_item                r2_item;
    logic [DIR_W-1:0]         r_drive_dir;

    logic                     free1, free2, mv1, acc;
    logic [ANGLE_BITS-1:0]    angle;
    logic signed [DW-1:0]     raw_diff, diff;
    logic [COUNT_W-1:0]       n_turn_count;
    logic signed [ERR_W-1:0]  err, db_x;
    logic                     pos_drv, neg_drv;
    logic [DIR_W-1:0]         n_drive_dir;
    logic [SEL_W-1:0]         n_sel;

    // Stage flow control
    assign free2      = !r2_valid || i_ready;
    assign mv1        = r1_valid && free2;
    assign free1      = !r1_valid || mv1;
    assign i_in.ready = free1;
    assign acc        = i_in.valid && free1;

    // Angle step, corrected to the shorter way round
    assign angle    = i_in.encoder_frame[FRAME_W-1 -: ANGLE_BITS];
    assign raw_diff = $signed({2'b00, angle}) - $signed({2'b00, r_last_angle});

    always_comb begin
        if (raw_diff > HALF_S) begin
            diff = raw_diff - FULL_S;
        end else if (raw_diff < -HALF_S) begin
            diff = raw_diff + FULL_S;
        end else begin
            diff = raw_diff;
        end
    end

    assign n_turn_count = r_turn_count - {{(COUNT_W-DW){diff[DW-1]}}, diff};

    // Advance stage 1 and the count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r_last_angle <= '0;
            r_turn_count <= '0;
        end else begin
            if (free1) begin
                r1_valid <= i_in.valid;
            end
            if (acc) begin
                r_last_angle <= angle;
                r_turn_count <= i_in.zero_count ? '0 : n_turn_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_goal <= i_in.target_count;
            r1_lim  <= i_in.limit_pressed;
            r1_zero <= i_in.zero_count;
        end
    end

    // Error at full width, compared against the deadband
    assign err     = $signed({r1_goal[GOAL_W-1], r1_goal})
                   - $signed({r_turn_count[COUNT_W-1], r_turn_count});
    assign db_x    = $signed({{(ERR_W-DB_W){1'b0}}, i_cfg.deadband_half});
    assign pos_drv = err > db_x;
    assign neg_drv = err < -db_x;

    // Direction hysteresis and drive select
    always_comb begin
        n_drive_dir = r_drive_dir;
        n_sel       = SEL_STOP;
        if (r1_zero) begin
            n_drive_dir = DIR_IDLE;
        end else begin
            if (pos_drv) begin
                n_drive_dir = DIR_POS;
                n_sel       = SEL_POS;
            end else if (neg_drv) begin
                n_drive_dir = DIR_NEG;
                n_sel       = SEL_NEG;
            end else if (r_drive_dir == DIR_POS && err > 0) begin
                n_sel       = SEL_POS;
            end else if (r_drive_dir == DIR_NEG && err < 0) begin
                n_sel       = SEL_NEG;
            end else begin
                n_drive_dir = DIR_IDLE;
            end
            // Limit switch pressed with count above goal: stop
            if (r1_lim && err < 0) begin
                n_sel = SEL_STOP;
            end
        end
    end

    // Advance stage 2 and the direction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid    <= 1'b0;
            r_drive_dir <= DIR_IDLE;
        end else begin
            if (free2) begin
                r2_valid <= r1_valid;
            end
            if (mv1) begin
                r_drive_dir <= n_drive_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r2_item.err   <= err;
            r2_item.sel   <= n_sel;
            r2_item.count <= r_turn_count;
            r2_item.dir   <= n_drive_dir;
        end
    end

    assign o_valid = r2_valid;
    assign o_item  = r2_item;

    // A zero request leaves the direction idle
    a_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv1 && r1_zero |=> r_drive_dir == DIR_IDLE)
        else $error("direction not idle after zero request");

    // Idle direction always selects stop
    a_idle_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid && r2_item.dir == DIR_IDLE |-> r2_item.sel == SEL_STOP)
        else $error("idle direction with active drive");

endmodule

FILE: rtl/epc_drive.sv
// ----------------------------------------------------------------------------
// Encoder position controller drive stages
// Scales the error by the gain, clamps each side and registers the result.
// ----------------------------------------------------------------------------
module epc_drive import epc_pkg::*; #(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_err_item  i_item,
    epc_out_if.source  o_res
);

    localparam logic signed [PROD_W-1:0] STOP_X = PROD_W'(STOP_PW);

    // Stage 3: product
    logic                      r3_valid;
    logic signed [PROD_W-1:0]  r3_prod;
    logic [SEL_W-1:0]          r3_sel;
    logic [COUNT_W-1:0]        r3_count;
    logic [DIR_W-1:0]          r3_dir;

    // Stage 4: result
    logic                      r4_valid;
    logic [PW_W-1:0]           r4_pw;
    logic [COUNT_W-1:0]        r4_count;
    logic [DIR_W-1:0]          r4_dir;

    logic                      free3, free4;
    logic signed [PROD_W-1:0]  pwm, lim_x, floor_x, low_v, clamp_v;
    logic [PW_W-1:0]           n_pw;

    // Stage flow control
    assign free4   = !r4_valid || o_res.ready;
    assign free3   = !r3_valid || free4;
    assign o_ready = free3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (free3) begin
                r3_valid <= i_valid;
            end
            if (free4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // Multiply error by unsigned gain
    always_ff @(posedge i_clk) begin
        if (free3 && i_valid) begin
            r3_prod  <= $signed(i_item.err) * $signed({1'b0, i_cfg.gain_q8});
            r3_sel   <= i_item.sel;
            r3_count <= i_item.count;
            r3_dir   <= i_item.dir;
        end
    end

    // Floor scale, offset from stop, clamp the active side
    assign pwm = (r3_prod >>> GAIN_FRAC_BITS) + STOP_X;

    always_comb begin
        if (r3_sel == SEL_NEG) begin
            lim_x   = $signed({{(PROD_W-PW_W){1'b0}}, i_cfg.neg_side_limit});
            floor_x = $signed({{(PROD_W-PW_W){1'b0}}, NEG_FLOOR});
        end else begin
            lim_x   = $signed({{(PROD_W-PW_W){1'b0}}, i_cfg.pos_side_limit});
            floor_x = $signed({{(PROD_W-PW_W){1'b0}}, POS_FLOOR});
        end
    end

    assign low_v   = (pwm < lim_x) ? pwm : lim_x;
    assign clamp_v = (low_v > floor_x) ? low_v : floor_x;

    always_comb begin
        case (r3_sel)
            SEL_POS, SEL_NEG: n_pw = clamp_v[PW_W-1:0];
            default:          n_pw = STOP_PW;
        endcase
    end

    // Hold the result until transferred
    always_ff @(posedge i_clk) begin
        if (free4 && r3_valid) begin
            r4_pw    <= n_pw;
            r4_count <= r3_count;
            r4_dir   <= r3_dir;
        end
    end

    assign o_res.valid          = r4_valid;
    assign o_res.drive_pw       = r4_pw;
    assign o_res.position_count = r4_count;
    assign o_res.direction      = r4_dir;

    // Positive drive never falls below its floor
    a_pos_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid && free4 && r3_sel == SEL_POS |=> r4_pw >= POS_FLOOR)
        else $error("positive drive below floor");

    // Idle direction reports stop
    a_idle_pw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && r4_dir == DIR_IDLE |-> r4_pw == STOP_PW)
        else $error("idle direction without stop pulse");

endmodule

FILE: rtl/encoder_position_p_controller_core.sv
// Throughput: one item per cycle while the output is not back-pressured; four
// registered stages (count, error, product, result) each hold one item and
// advance when the next frees up.
// Reset (synchronous, active low) clears the count, last angle and direction
// to zero/idle, empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
// Encoder position controller top level
// Multiturn encoder unwrap with proportional drive and deadband hysteresis.
// ----------------------------------------------------------------------------
module encoder_position_p_controller_core import epc_pkg::*; #(
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    epc_in_if.sink                i_in,
    epc_out_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      cfg;
    logic      trk_valid;
    logic      drv_ready;
    t_err_item trk_item;

    // Configuration registers
    epc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Count and direction tracking
    epc_track #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_valid (trk_valid),
        .i_ready (drv_ready),
        .o_item  (trk_item)
    );

    // Gain, clamp and result register
    epc_drive #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (trk_valid),
        .o_ready (drv_ready),
        .i_item  (trk_item),
        .o_res   (o_res)
    );

endmodule
